// ===== rtl/core/rdsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdsm_pkg - shared types and constants for the dot-star regex matcher
// Token coding, configuration register indexes, the per-cell control beat
// and the links that ripple from one position cell to the next.
// ----------------------------------------------------------------------------
package rdsm_pkg;

	// widths fixed by the register map
	localparam int TOK_W   = 8;   // one byte per token
	localparam int LEN_W   = 5;   // pattern_length register
	localparam int STAR_W  = 16;  // star_mask register
	localparam int CHARS_W = 64;  // each token_chars register
	localparam int CFG_W   = 64;  // widest register
	localparam int IDX_W   = 2;   // register index

	// token byte that matches any character ('.')
	localparam logic [TOK_W-1:0] ANY_CHAR = 8'd46;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_CHARS_LOW  = 2'd0,
		REG_CHARS_HIGH = 2'd1,
		REG_STAR_MASK  = 2'd2,
		REG_PAT_LEN    = 2'd3
	} cfg_reg_t;

	// control broadcast to every cell for one input beat
	typedef struct packed {
		logic             load;     // input beat accepted this cycle
		logic             restart;  // end-of-string beat
		logic [TOK_W-1:0] sym;      // string character
	} cell_ctl_t;

	// signals handed from cell i to cell i+1
	typedef struct packed {
		logic close;   // current set reaches i+1 by skipping a starred token
		logic adv;     // character consumed a plain token, next set gets i+1
		logic close2;  // next set reaches i+1 by skipping a starred token
	} link_t;

	// per-cell contribution to the final-position test
	typedef struct packed {
		logic hit_end;   // closed current set holds the final position
		logic hit_char;  // closed next set holds the final position
	} fin_t;

	// one result beat
	typedef struct packed {
		logic matched;
		logic at_end;
	} result_t;

endpackage : rdsm_pkg
`default_nettype wire

// ===== rtl/core/regex_dot_star_matcher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// regex_dot_star_matcher - whole-string matcher for '.' and '*' patterns
// Bit-parallel NFA built as a row of position cells.
// ----------------------------------------------------------------------------
// Usage:
//   Load the pattern through the cfg port while idle: token bytes (46 is '.'),
//   star_mask (token i repeats zero or more times) and pattern_length.
//   Input beats (cmd, symbol) arrive on in_valid/in_stall. cmd 0 feeds one
//   character, cmd 1 ends the string and returns to the start position.
//   Every input beat gives exactly one output beat (matched, at_end):
//   matched tells whether the characters since the last restart match the
//   whole pattern; at_end marks the answer to an end beat.
// Throughput:
//   A beat's result is registered into the output register, or into the skid
//   slot while the output stalls. One beat per cycle while the output does
//   not stall: all positions step in parallel, and the cycle is set by the closure
//   ripple through the row of MAX_TOKENS+1 cells (twice: current set, then next set).
// Reset:
//   Config registers and valid flags clear to zero, only position 0 is active, no output pending.
// Stall:
//   A stalled result holds on the outputs; one further beat goes to a skid
//   slot, after which in_stall rises until the output drains.
// ----------------------------------------------------------------------------
module regex_dot_star_matcher #(
	parameter int MAX_TOKENS = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	// configuration
	input  wire                         cfg_we,
	input  wire [rdsm_pkg::IDX_W-1:0]   cfg_index,
	input  wire [rdsm_pkg::CFG_W-1:0]   cfg_data,
	// input channel
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire                         cmd,
	input  wire [rdsm_pkg::TOK_W-1:0]   symbol,
	// output channel
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic                        matched,
	output logic                        at_end
);
	import rdsm_pkg::*;

	localparam int NCELL = MAX_TOKENS + 1;

	logic [CHARS_W-1:0] chars_low_q, chars_high_q;
	logic [STAR_W-1:0]  star_q;
	logic [LEN_W-1:0]   pat_len_q;
	logic [LEN_W-1:0]   len_eff;

	logic               accept;
	cell_ctl_t          ctl;
	logic [TOK_W-1:0]   tok      [NCELL];
	logic               star_bit [NCELL];
	link_t              links    [NCELL];
	fin_t               fins     [NCELL];
	logic [NCELL-1:0]   hit_end_v, hit_char_v;
	result_t            res, res_out;
	logic               full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_low_q  <= '0;
			chars_high_q <= '0;
			star_q       <= '0;
			pat_len_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CHARS_LOW:  chars_low_q  <= cfg_data;
				REG_CHARS_HIGH: chars_high_q <= cfg_data;
				REG_STAR_MASK:  star_q       <= cfg_data[STAR_W-1:0];
				REG_PAT_LEN:    pat_len_q    <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp length to the number of token cells
	assign len_eff = (pat_len_q > LEN_W'(MAX_TOKENS)) ? LEN_W'(MAX_TOKENS) : pat_len_q;

	assign accept      = in_valid & ~full;
	assign in_stall    = full;
	assign ctl.load    = accept;
	assign ctl.restart = cmd;
	assign ctl.sym     = symbol;

	assign links[0] = '0;

	// row of position cells
	generate
		for (genvar i = 0; i < NCELL; i++) begin : g_cell
			// token and star bit for this position; the last cell has no token
			if (i < MAX_TOKENS && i < 8) begin : g_lo
				assign tok[i]      = chars_low_q[8*i +: TOK_W];
				assign star_bit[i] = star_q[i];
			end else if (i < MAX_TOKENS) begin : g_hi
				assign tok[i]      = chars_high_q[8*(i-8) +: TOK_W];
				assign star_bit[i] = star_q[i];
			end else begin : g_tail
				assign tok[i]      = '0;
				assign star_bit[i] = 1'b0;
			end

			if (i < NCELL - 1) begin : g_mid
				rdsm_cell #(.IDX(i)) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.ctl      (ctl),
					.len_eff  (len_eff),
					.token    (tok[i]),
					.star     (star_bit[i]),
					.link_in  (links[i]),
					.link_out (links[i+1]),
					.fin      (fins[i])
				);
			end else begin : g_last
				rdsm_cell #(.IDX(i)) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.ctl      (ctl),
					.len_eff  (len_eff),
					.token    (tok[i]),
					.star     (star_bit[i]),
					.link_in  (links[i]),
					.link_out (),
					.fin      (fins[i])
				);
			end

			assign hit_end_v[i]  = fins[i].hit_end;
			assign hit_char_v[i] = fins[i].hit_char;
		end
	endgenerate

	// result of this beat
	assign res.at_end  = cmd;
	assign res.matched = cmd ? (|hit_end_v) : (|hit_char_v);

	rdsm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (res_out)
	);

	assign matched = res_out.matched;
	assign at_end  = res_out.at_end;

endmodule : regex_dot_star_matcher
`default_nettype wire

// ===== rtl/core/rdsm_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdsm_cell - one pattern position of the NFA
// Holds the active bit of its position, closes over a starred token from
// the left neighbor, steps on the incoming character and hands the result on.
// ----------------------------------------------------------------------------
module rdsm_cell #(
	parameter int IDX = 0
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  rdsm_pkg::cell_ctl_t       ctl,
	input  wire [rdsm_pkg::LEN_W-1:0] len_eff,
	input  wire [rdsm_pkg::TOK_W-1:0] token,
	input  wire                       star,
	input  rdsm_pkg::link_t           link_in,
	output rdsm_pkg::link_t           link_out,
	output rdsm_pkg::fin_t            fin
);
	import rdsm_pkg::*;

	localparam logic [LEN_W-1:0] POS   = LEN_W'(IDX);
	localparam logic             START = (IDX == 0);

	logic act_q;
	logic lt_len, le_len, eq_len;
	logic hit;
	logic cur;   // closed current set at this position
	logic nxt;   // next set before closure
	logic nxt_c; // next set after closure

	// position against the pattern length
	assign lt_len = (POS < len_eff);
	assign le_len = (POS <= len_eff);
	assign eq_len = (POS == len_eff);

	assign hit = (token == ANY_CHAR) || (token == ctl.sym);

	// closure of the stored set, then one character step
	assign cur            = (act_q | link_in.close) & le_len;
	assign link_out.close = cur & star & lt_len;
	assign nxt            = (cur & hit & star & lt_len) | link_in.adv;
	assign link_out.adv   = cur & hit & ~star & lt_len;

	// closure of the new set for the result
	assign nxt_c           = (nxt | link_in.close2) & le_len;
	assign link_out.close2 = nxt_c & star & lt_len;

	assign fin.hit_end  = cur & eq_len;
	assign fin.hit_char = nxt_c & eq_len;

	// active bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= START;
		end else if (ctl.load) begin
			act_q <= ctl.restart ? START : nxt;
		end
	end

endmodule : rdsm_cell
`default_nettype wire

// ===== rtl/core/rdsm_skid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdsm_skid - two-entry output buffer
// Output register plus a skid slot, so a new beat is taken while the
// current result waits; stall to the input comes straight from a flop.
// ----------------------------------------------------------------------------
module rdsm_skid (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  rdsm_pkg::result_t    push_data,
	output logic                 full,
	output logic                 out_valid,
	input  wire                  out_stall,
	output rdsm_pkg::result_t    out_data
);
	import rdsm_pkg::*;

	logic    main_valid_q, skid_valid_q;
	result_t main_q, skid_q;
	logic    main_free;

	assign main_free = ~main_valid_q | ~out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q | push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule : rdsm_skid
`default_nettype wire

// ===== rtl/core/rdsm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdsm_checker - port-level checks for the dot-star regex matcher
// Watches the two channels of the top level over time.
// ----------------------------------------------------------------------------
module rdsm_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_stall,
	input wire cmd,
	input wire out_valid,
	input wire out_stall,
	input wire matched,
	input wire at_end
);

	// reset leaves nothing pending
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> (!out_valid && !in_stall))
		else $error("output or stall active during reset");

	// input only stalls while a result is held
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// with the output empty, a beat shows up next cycle with its own end flag
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_valid) |=> (out_valid && at_end == $past(cmd)))
		else $error("result beat missing or end flag wrong");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(matched) && $stable(at_end)))
		else $error("stalled output beat changed");

endmodule : rdsm_checker

bind regex_dot_star_matcher rdsm_checker u_rdsm_checker (.*);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for regex_dot_star_matcher
// Loads '.'/'*' patterns through the config port, streams character and
// end-of-string beats with random gaps and output stalls, and compares every
// result beat with a bit-parallel position-set predictor kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
	import rdsm_pkg::*;

	localparam int     N_TOKENS    = 16;
	localparam int     RAND_BEATS  = 1250;
	localparam longint CYCLE_LIMIT = 400000;

	// block inputs, all known from time zero
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data  = '0;
	logic               in_valid  = 1'b0;
	logic               cmd       = 1'b0;
	logic [TOK_W-1:0]   symbol    = '0;
	logic               out_stall = 1'b0;
	wire                in_stall;
	wire                out_valid;
	wire                matched;
	wire                at_end;

	// shadow of the pattern registers and of the reached positions
	logic [63:0] tok_lo   = '0;
	logic [63:0] tok_hi   = '0;
	logic [15:0] star_bits = '0;
	logic [4:0]  tok_count = '0;
	logic [16:0] reached  = 17'd1;

	result_t     pending_matches[$];
	logic [7:0]  text[$];

	int     fail_count    = 0;
	int     beats_sent    = 0;
	int     results_seen  = 0;
	int     strings_done  = 0;
	int     whole_matches = 0;
	int     reg_writes    = 0;
	int     settings_used = 0;
	int     stall_left    = 0;
	bit     src_quiet     = 1'b0;
	bit     sink_quiet    = 1'b0;
	longint cycles        = 0;

	regex_dot_star_matcher #(.MAX_TOKENS(N_TOKENS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.symbol    (symbol),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.matched   (matched),
		.at_end    (at_end)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// lengths above the token count clamp to it
	function automatic int unsigned used_len();
		return (tok_count > N_TOKENS) ? N_TOKENS : tok_count;
	endfunction

	function automatic logic [7:0] token_at(int unsigned i);
		return (i < 8) ? tok_lo[8*i +: 8] : tok_hi[8*(i-8) +: 8];
	endfunction

	// drop positions past the length, then skip over starred tokens
	function automatic logic [16:0] take_skips(logic [16:0] s);
		int unsigned len;
		logic [17:0] keep;
		len  = used_len();
		keep = (18'd1 << (len + 1)) - 18'd1;
		s    = s & keep[16:0];
		for (int unsigned i = 0; i < len; i++)
			if (s[i] && star_bits[i])
				s[i+1] = 1'b1;
		return s;
	endfunction

	// one character: starred tokens stay put, plain tokens move on
	function automatic logic [16:0] consume(logic [16:0] s, logic [7:0] c);
		int unsigned len;
		logic [16:0] r;
		logic [7:0]  t;
		len = used_len();
		r   = '0;
		for (int unsigned i = 0; i < len; i++) begin
			t = token_at(i);
			if (s[i] && (t == ANY_CHAR || t == c)) begin
				if (star_bits[i])
					r[i] = 1'b1;
				else
					r[i+1] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic result_t match_step(logic end_beat, logic [7:0] c);
		result_t r;
		logic [16:0] closed;
		if (end_beat) begin
			closed    = take_skips(reached);
			r.matched = closed[used_len()];
			r.at_end  = 1'b1;
			reached   = 17'd1;
		end else begin
			reached   = consume(take_skips(reached), c);
			closed    = take_skips(reached);
			r.matched = closed[used_len()];
			r.at_end  = 1'b0;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- helpers

	// mostly short pauses, now and then a long one
	function automatic int unsigned pause_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 85)
			return $urandom_range(1, 3);
		else if (p < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// token bytes lean on a small alphabet so strings hit the pattern
	function automatic logic [7:0] rand_token();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 8'h61 + 8'($urandom_range(0, 2));
			5, 6:          return ANY_CHAR;
			7:             return 8'($urandom_range(0, 255));
			default: begin
				case ($urandom_range(0, 2))
					0:       return 8'h00;
					1:       return 8'hFF;
					default: return 8'h2A;
				endcase
			end
		endcase
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_CHARS_LOW:  tok_lo    = data;
			REG_CHARS_HIGH: tok_hi    = data;
			REG_STAR_MASK:  star_bits = data[15:0];
			REG_PAT_LEN:    tok_count = data[4:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// full pattern load; unused upper bits carry junk
	task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
			input logic [15:0] stars, input logic [4:0] len);
		logic [63:0] junk;
		write_reg(REG_CHARS_LOW, lo);
		write_reg(REG_CHARS_HIGH, hi);
		junk = {$urandom, $urandom};
		junk[15:0] = stars;
		write_reg(REG_STAR_MASK, junk);
		junk = {$urandom, $urandom};
		junk[4:0] = len;
		write_reg(REG_PAT_LEN, junk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// one input beat; the expectation is formed at the accepting edge
	task automatic send_beat(input logic end_beat, input logic [7:0] c);
		int unsigned gap;
		in_valid <= 1'b1;
		cmd      <= end_beat;
		symbol   <= c;
		do @(posedge clk); while (in_stall);
		pending_matches.push_back(match_step(end_beat, c));
		beats_sent++;
		gap = (src_quiet || $urandom_range(0, 1)) ? 0 : pause_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input bit with_end);
		foreach (text[k])
			send_beat(1'b0, text[k]);
		if (with_end) begin
			send_beat(1'b1, 8'($urandom_range(0, 255)));
			strings_done++;
		end
	endtask

	// hold the sender until every result is back, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// a string shaped by the current pattern, sometimes damaged, sometimes noise
	task automatic build_text();
		int unsigned reps;
		int unsigned pos;
		logic [7:0]  t;
		text.delete();
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(0, 10))
				text.push_back($urandom_range(0, 1) ? rand_token() : 8'($urandom_range(0, 255)));
			return;
		end
		for (int unsigned i = 0; i < used_len(); i++) begin
			reps = star_bits[i] ? $urandom_range(0, 3) : 1;
			t    = token_at(i);
			repeat (reps)
				text.push_back((t == ANY_CHAR) ? 8'($urandom_range(0, 255)) : t);
		end
		if ($urandom_range(0, 3) == 0) begin
			pos = $urandom_range(0, text.size());
			case ($urandom_range(0, 2))
				0: if (pos < text.size()) text[pos] = rand_token();
				1: if (pos < text.size()) text.delete(pos);
				default: text.insert(pos, rand_token());
			endcase
		end
	endtask

	// ---------------------------------------------------------------- tests

	// reset values: empty pattern matches only the empty string; byte 0 is data
	task automatic test_reset_empty();
		send_beat(1'b1, 8'h00);
		text = '{8'h00};
		send_text(1'b1);
		wait_idle();
	endtask

	// literal tokens at the byte extremes, '*' byte as a literal, '.' wildcard
	task automatic test_literals();
		load_pattern(64'h0000_00FF_2E2A_0061, 64'h0, 16'h0000, 5'd5);
		text = '{8'h61, 8'h00, 8'h2A, 8'h7E, 8'hFF};
		send_text(1'b1);
		text = '{8'h61, 8'h2A};
		send_text(1'b1);
		wait_idle();
	endtask

	// a* b .* : skipped and repeated stars
	task automatic test_star_repeat();
		load_pattern(64'h0000_0000_002E_6261, 64'h0, 16'h0005, 5'd3);
		text = '{8'h62};
		send_text(1'b1);
		text = '{8'h61, 8'h61, 8'h62, 8'h80};
		send_text(1'b1);
		wait_idle();
	endtask

	// length above the token count clamps; all tokens '.' and starred
	task automatic test_length_clamp();
		load_pattern({8{ANY_CHAR}}, {8{ANY_CHAR}}, 16'hFFFF, 5'd31);
		send_beat(1'b1, 8'hFF);
		text = '{8'hFF};
		send_text(1'b1);
		wait_idle();
	endtask

	// pattern changes while a string is open apply from the next beat on
	task automatic test_midstring_update();
		load_pattern(64'h6261, 64'h0, 16'h0000, 5'd2);
		send_beat(1'b0, 8'h61);
		wait_idle();
		write_reg(REG_CHARS_LOW, 64'h6361);
		cfg_we <= 1'b0;
		send_beat(1'b0, 8'h63);
		wait_idle();
		// shrinking the length drops the reached final position
		write_reg(REG_PAT_LEN, 64'd1);
		cfg_we <= 1'b0;
		send_beat(1'b1, 8'h00);
		wait_idle();
	endtask

	// random patterns, each followed by strings built from it
	task automatic test_random_patterns();
		int          done;
		int          phase;
		int          start;
		int unsigned quota;
		int unsigned p;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  len;
		done  = 0;
		phase = 0;
		while (done < RAND_BEATS) begin
			case (phase)
				0: load_pattern('1, '1, 16'hFFFF, 5'd31);
				1: load_pattern('0, '0, 16'h0000, 5'd16);
				default: begin
					for (int k = 0; k < 8; k++) begin
						lo[8*k +: 8] = rand_token();
						hi[8*k +: 8] = rand_token();
					end
					p = $urandom_range(0, 9);
					if (p < 6)
						len = 5'($urandom_range(0, 8));
					else if (p < 9)
						len = 5'($urandom_range(9, 16));
					else
						len = 5'($urandom_range(17, 31));
					load_pattern(lo, hi, 16'($urandom_range(0, 65535)), len);
				end
			endcase
			// every fourth setting runs at full rate on both sides
			src_quiet  = (phase % 4 == 3);
			sink_quiet = (phase % 4 == 3);
			quota = $urandom_range(40, 80);
			start = beats_sent;
			while (beats_sent - start < quota) begin
				build_text();
				send_text(1'b1);
			end
			// sometimes leave a string open across the next register load
			if ($urandom_range(0, 2) == 0) begin
				build_text();
				send_text(1'b0);
			end
			wait_idle();
			done += beats_sent - start;
			phase++;
		end
		src_quiet  = 1'b0;
		sink_quiet = 1'b0;
	endtask

	// ---------------------------------------------------------------- sink and checker

	// random output stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!sink_quiet && $urandom_range(0, 3) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= pause_len() - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each accepted result beat with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_matches.size() == 0) begin
				$error("unexpected result beat: matched %0d at_end %0d", matched, at_end);
				fail_count++;
			end else begin
				want = pending_matches.pop_front();
				if (matched !== want.matched) begin
					$error("matched: expected %0d, actual %0d", want.matched, matched);
					fail_count++;
				end
				if (at_end !== want.at_end) begin
					$error("at_end: expected %0d, actual %0d", want.at_end, at_end);
					fail_count++;
				end
				if (want.at_end && want.matched)
					whole_matches++;
			end
		end
	end

	// run limit
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_empty();
		test_literals();
		test_star_repeat();
		test_length_clamp();
		test_midstring_update();
		test_random_patterns();
		wait_idle();
		repeat (5) @(posedge clk);
		$display("run covered %0d beats in %0d strings, %0d of them whole matches",
			beats_sent, strings_done, whole_matches);
		$display("%0d pattern settings, %0d register writes, %0d results, %0d errors",
			settings_used, reg_writes, results_seen, fail_count);
		if (fail_count == 0 && pending_matches.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/rdsm_pkg.sv
rtl/core/rdsm_cell.sv
rtl/core/rdsm_skid.sv
rtl/core/regex_dot_star_matcher.sv
rtl/core/rdsm_checker.sv
tb/sv/testbench.sv
